### rtl/rsx_pkg.sv
// shared types, constants and codes for the register and stack execute unit
// no dependencies; imported by every module of the block
package rsx_pkg;

   // sizes
   localparam int WORD_BITS   = 16;
   localparam int REG_COUNT   = 8;
   localparam int REG_BITS    = 3;
   localparam int STACK_DEPTH = 1024;
   localparam int SP_BITS     = $clog2(STACK_DEPTH + 1);
   localparam int SA_BITS     = $clog2(STACK_DEPTH);
   localparam int LEVEL_BITS  = 11;

   // operation codes
   localparam logic [2:0] OP_MOV  = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_PUSH = 3'd3;
   localparam logic [2:0] OP_POP  = 3'd4;
   localparam logic [2:0] OP_XCHG = 3'd5;

   // status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // request beat
   typedef struct packed {
      logic [2:0]           operation;
      logic [REG_BITS-1:0]  first_reg;
      logic [REG_BITS-1:0]  second_reg;
      logic [15:0]          immediate;
   } req_type;

   // response beat
   typedef struct packed {
      logic [15:0]           first_value;
      logic [15:0]           second_value;
      logic [LEVEL_BITS-1:0] stack_level;
      logic [1:0]            status;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic exec;
      logic swap_wr;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_xchg;
   } dp_status_type;

endpackage

### rtl/rsx_ctrl.sv
// sequencing state machine of the register and stack execute unit
// depends on rsx_pkg for the command and status structs
module rsx_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_strobe,
   output rsx_pkg::cmd_type      cmd,
   input  rsx_pkg::dp_status_type dp_status
);
   import rsx_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SWAP = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = (state_ff == S_DONE);

   // commands
   assign cmd.load    = accept;
   assign cmd.exec    = (state_ff == S_EXEC);
   assign cmd.swap_wr = (state_ff == S_SWAP);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = dp_status.is_xchg ? S_SWAP : S_DONE;
         end
         S_SWAP: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy && !rsp_strobe))
      else $error("accepted beat did not start execution");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("unit stayed busy after response beat");
   a_swap_order: assert property (@(posedge clock) disable iff (reset)
      cmd.swap_wr |-> ($past(cmd.exec) && $past(dp_status.is_xchg)))
      else $error("second register write without exchange");

endmodule

### rtl/rsx_datapath.sv
// register file, word stack and result register of the execute unit
// depends on rsx_pkg for types, sizes and codes
module rsx_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  rsx_pkg::req_type       req_payload,
   input  rsx_pkg::cmd_type       cmd,
   output rsx_pkg::dp_status_type dp_status,
   output rsx_pkg::rsp_type       rsp_payload
);
   import rsx_pkg::*;

   // storage
   logic [WORD_BITS-1:0] reg_mem [REG_COUNT];
   logic [REG_COUNT-1:0] reg_valid_ff;
   logic [WORD_BITS-1:0] stack_mem [STACK_DEPTH];
   logic [SP_BITS-1:0]   sp_ff;
   logic [SP_BITS-1:0]   sp_in;

   // latched request and registered reads
   req_type              req_ff;
   logic [WORD_BITS-1:0] rd_a_ff;
   logic [WORD_BITS-1:0] rd_b_ff;
   logic                 va_ff;
   logic                 vb_ff;
   logic [WORD_BITS-1:0] stk_rd_ff;
   logic [WORD_BITS-1:0] swap_ff;
   rsp_type              rsp_ff;

   // execute stage values
   logic [WORD_BITS-1:0] a_val;
   logic [WORD_BITS-1:0] b_val;
   logic [WORD_BITS-1:0] new_a;
   logic [WORD_BITS-1:0] new_b;
   logic                 wr_a;
   logic                 push_ok;
   logic [1:0]           status;
   logic [SA_BITS-1:0]   pop_addr;
   logic [REG_BITS-1:0]  wr_idx;
   logic [WORD_BITS-1:0] wr_data;
   logic                 wr_en;

   assign pop_addr          = SA_BITS'(sp_ff - SP_BITS'(1));
   assign dp_status.is_xchg = (req_ff.operation == OP_XCHG);
   assign rsp_payload       = rsp_ff;

   // unwritten registers read as zero
   assign a_val = va_ff ? rd_a_ff : '0;
   assign b_val = vb_ff ? rd_b_ff : '0;

   // operation decode
   always_comb begin
      new_a   = a_val;
      wr_a    = 1'b0;
      push_ok = 1'b0;
      status  = ST_DONE;
      sp_in   = sp_ff;
      unique case (req_ff.operation)
         OP_MOV: begin
            new_a = WORD_BITS'(req_ff.immediate);
            wr_a  = 1'b1;
         end
         OP_ADD: begin
            new_a = a_val + b_val;
            wr_a  = 1'b1;
         end
         OP_SUB: begin
            new_a = a_val - b_val;
            wr_a  = 1'b1;
         end
         OP_PUSH: begin
            if (sp_ff < SP_BITS'(STACK_DEPTH)) begin
               push_ok = 1'b1;
               sp_in   = sp_ff + SP_BITS'(1);
            end else begin
               status = ST_FULL;
            end
         end
         OP_POP: begin
            if (sp_ff != '0) begin
               new_a = stk_rd_ff;
               wr_a  = 1'b1;
               sp_in = sp_ff - SP_BITS'(1);
            end else begin
               status = ST_EMPTY;
            end
         end
         OP_XCHG: begin
            new_a = b_val;
            wr_a  = 1'b1;
         end
         default: begin
            new_a = a_val;
         end
      endcase
   end

   // second register after the step
   always_comb begin
      if (req_ff.first_reg == req_ff.second_reg) begin
         new_b = new_a;
      end else if (req_ff.operation == OP_XCHG) begin
         new_b = a_val;
      end else begin
         new_b = b_val;
      end
   end

   // single register write port: first register in execute, second in swap
   assign wr_en   = (cmd.exec && wr_a) || cmd.swap_wr;
   assign wr_idx  = cmd.swap_wr ? req_ff.second_reg : req_ff.first_reg;
   assign wr_data = cmd.swap_wr ? swap_ff : new_a;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         reg_mem[wr_idx] <= wr_data;
      end
      if (cmd.load) begin
         rd_a_ff <= reg_mem[req_payload.first_reg];
         rd_b_ff <= reg_mem[req_payload.second_reg];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_valid_ff <= '0;
      end else if (wr_en) begin
         reg_valid_ff[wr_idx] <= 1'b1;
      end
   end

   // stack memory; entries below the pointer are always written
   always_ff @(posedge clock) begin
      if (cmd.exec && push_ok) begin
         stack_mem[SA_BITS'(sp_ff)] <= a_val;
      end
      if (cmd.load) begin
         stk_rd_ff <= stack_mem[pop_addr];
      end
   end

   // stack pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else if (cmd.exec) begin
         sp_ff <= sp_in;
      end
   end

   // request latch and read valid bits
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
         va_ff  <= reg_valid_ff[req_payload.first_reg];
         vb_ff  <= reg_valid_ff[req_payload.second_reg];
      end
   end

   // result register and exchange data
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         swap_ff             <= a_val;
         rsp_ff.first_value  <= 16'(new_a);
         rsp_ff.second_value <= 16'(new_b);
         rsp_ff.stack_level  <= LEVEL_BITS'(sp_in);
         rsp_ff.status       <= status;
      end
   end

   // checks
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_BITS'(STACK_DEPTH))
      else $error("stack pointer beyond stack depth");
   a_sp_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.exec |=> $stable(sp_ff))
      else $error("stack pointer moved outside execute");

endmodule

### rtl/register_stack_execute_unit.sv
// top level of the register and stack execute unit
// depends on rsx_pkg, rsx_ctrl and rsx_datapath
//
//  channel   ports                          direction  handshake
//  request   start, busy, req_payload       in         taken when start and not busy
//  response  rsp_strobe, rsp_payload        out        one-cycle strobe, no back-pressure
//
// the response strobe is high in state S_DONE, reached from the accepting edge through
// S_EXEC and, for exchange, S_SWAP, set by the registered reads of the register file
// and stack and the single register write port; busy drops in the cycle after the
// strobe, so a new beat is not taken until the last response has been given.
// synchronous active-high reset clears registers (valid bits) and the pointer;
// the stack needs no clearing since the pointer bounds every read.
// the receiver cannot stall; each response beat appears exactly once.
module register_stack_execute_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rsx_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output rsx_pkg::rsp_type rsp_payload
);
   import rsx_pkg::*;

   cmd_type       cmd;
   dp_status_type dp_status;

   // sequencing
   rsx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .dp_status  (dp_status)
   );

   // storage and arithmetic
   rsx_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .dp_status   (dp_status),
      .rsp_payload (rsp_payload)
   );

endmodule

### tb/sv/rsx_result_check.sv
// result checker for the register and stack execute unit: watches both channels,
// predicts each response beat and compares it field by field
// depends on rsx_pkg only
module rsx_result_check (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  rsx_pkg::req_type req_payload,
   input  logic             rsp_strobe,
   input  rsx_pkg::rsp_type rsp_payload,
   output int               fail_count,
   output int               pending
);
   import rsx_pkg::*;

   // predicted machine state
   logic [WORD_BITS-1:0]  gpr [REG_COUNT];
   logic [WORD_BITS-1:0]  stack_mem [STACK_DEPTH];
   logic [LEVEL_BITS-1:0] stack_ptr;

   // responses still owed by the block, oldest first
   rsp_type expected_results [$];
   rsp_type want;

   // count a failure, print only the first few
   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
   endtask

   task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
         note_failure($sformatf("%s expected 0x%0h got 0x%0h", name, exp_val, act_val));
      end
   endtask

   // apply one instruction to the predicted state, return the response it gives
   function automatic rsp_type execute_instruction(req_type ins);
      rsp_type res;
      int unsigned a;
      int unsigned b;
      logic [WORD_BITS-1:0] held;
      a = ins.first_reg % REG_COUNT;
      b = ins.second_reg % REG_COUNT;
      res.status = ST_DONE;
      case (ins.operation)
         OP_MOV: begin
            gpr[a] = ins.immediate[WORD_BITS-1:0];
         end
         OP_ADD: begin
            gpr[a] = gpr[a] + gpr[b];
         end
         OP_SUB: begin
            gpr[a] = gpr[a] - gpr[b];
         end
         OP_PUSH: begin
            if (stack_ptr < STACK_DEPTH) begin
               stack_mem[stack_ptr[SA_BITS-1:0]] = gpr[a];
               stack_ptr = stack_ptr + 1'b1;
            end else begin
               res.status = ST_FULL;
            end
         end
         OP_POP: begin
            if (stack_ptr != 0) begin
               stack_ptr = stack_ptr - 1'b1;
               gpr[a] = stack_mem[stack_ptr[SA_BITS-1:0]];
            end else begin
               res.status = ST_EMPTY;
            end
         end
         OP_XCHG: begin
            held = gpr[a];
            gpr[a] = gpr[b];
            gpr[b] = held;
         end
         default: begin
            // spare codes leave everything alone
         end
      endcase
      res.first_value  = gpr[a];
      res.second_value = gpr[b];
      res.stack_level  = stack_ptr;
      return res;
   endfunction

   // compare finished beats, then predict newly accepted ones
   always @(posedge clock) begin
      if (reset) begin
         foreach (gpr[i]) gpr[i] = '0;
         foreach (stack_mem[i]) stack_mem[i] = '0;
         stack_ptr = '0;
         expected_results.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               note_failure($sformatf("response beat 0x%0h with nothing expected", rsp_payload));
            end else begin
               want = expected_results.pop_front();
               check_field("first_value", want.first_value, rsp_payload.first_value);
               check_field("second_value", want.second_value, rsp_payload.second_value);
               check_field("stack_level", want.stack_level, rsp_payload.stack_level);
               check_field("status", want.status, rsp_payload.status);
            end
         end
         if (start && !busy) begin
            expected_results.push_back(execute_instruction(req_payload));
         end
      end
      pending = expected_results.size();
   end

endmodule

### tb/sv/testbench.sv
// top of the execute unit testbench: clock, reset, instruction stimulus and verdict
// depends on rsx_pkg, register_stack_execute_unit and rsx_result_check
module testbench;
   import rsx_pkg::*;

   // spare operation codes the block must ignore
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;
   int      fail_count;
   int      pending;

   int unsigned idle_pct;

   register_stack_execute_unit dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   rsx_result_check result_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #3000000;
      $display("Regression FAIL");
      $finish;
   end

   // send one beat, sometimes after a random gap, and hold it until accepted
   task automatic drive_beat(req_type beat);
      int unsigned gap;
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(6, 1);
         repeat (gap) begin
            @(negedge clock);
            start       <= 1'b0;
            req_payload <= req_type'($urandom());
         end
      end
      @(negedge clock);
      start       <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (busy);
   endtask

   task automatic issue(logic [2:0] op, int unsigned a, int unsigned b, logic [15:0] imm);
      req_type beat;
      beat.operation  = op;
      beat.first_reg  = REG_BITS'(a);
      beat.second_reg = REG_BITS'(b);
      beat.immediate  = imm;
      drive_beat(beat);
   endtask

   // random instruction; stack ops weighted, other codes optionally exclude the stack
   function automatic req_type random_instruction(int unsigned push_pct, int unsigned pop_pct,
                                                  bit stack_noise);
      req_type ins;
      int unsigned roll;
      roll = $urandom_range(99);
      ins.first_reg  = REG_BITS'($urandom_range(REG_COUNT - 1));
      ins.second_reg = REG_BITS'($urandom_range(REG_COUNT - 1));
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(3))
            0: ins.immediate = 16'h0000;
            1: ins.immediate = 16'hFFFF;
            2: ins.immediate = 16'h8000;
            default: ins.immediate = 16'h7FFF;
         endcase
      end else begin
         ins.immediate = 16'($urandom());
      end
      if (roll < push_pct) begin
         ins.operation = OP_PUSH;
      end else if (roll < push_pct + pop_pct) begin
         ins.operation = OP_POP;
      end else begin
         do ins.operation = 3'($urandom_range(7));
         while (!stack_noise && (ins.operation == OP_PUSH || ins.operation == OP_POP));
      end
      return ins;
   endfunction

   task automatic random_phase(int unsigned count, int unsigned pct);
      idle_pct = pct;
      repeat (count) drive_beat(random_instruction(20, 20, 1'b1));
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      idle_pct    = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty pop, wraps, same-register cases, spare codes
      issue(OP_POP, 0, 3, 16'h0000);
      issue(OP_MOV, 0, 0, 16'hFFFF);
      issue(OP_MOV, 7, 0, 16'h0001);
      issue(OP_MOV, 2, 0, 16'h8000);
      issue(OP_MOV, 3, 0, 16'h7FFF);
      issue(OP_ADD, 0, 7, 16'hFFFF);
      issue(OP_ADD, 2, 2, 16'h0000);
      issue(OP_ADD, 3, 3, 16'h5A5A);
      issue(OP_SUB, 1, 7, 16'h0000);
      issue(OP_SUB, 3, 3, 16'hA5A5);
      issue(OP_MOV, 4, 0, 16'h1234);
      issue(OP_XCHG, 1, 4, 16'h0000);
      issue(OP_XCHG, 4, 4, 16'hFFFF);
      issue(OP_PUSH, 1, 6, 16'h0000);
      issue(OP_PUSH, 7, 5, 16'h0000);
      issue(OP_POP, 5, 2, 16'h0000);
      issue(OP_POP, 6, 1, 16'h0000);
      issue(OP_POP, 6, 6, 16'h0000);
      issue(OP_SPARE_A, 5, 6, 16'hFFFF);
      issue(OP_SPARE_B, 7, 0, 16'h0000);

      // random mix under the sender idling patterns
      random_phase(130, 0);
      @(negedge clock);
      start <= 1'b0;
      wait (pending == 0);
      random_phase(130, 78);
      random_phase(130, 24);

      // drain outstanding responses and let the pipe settle
      @(negedge clock);
      start <= 1'b0;
      wait (pending == 0);
      repeat (12) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### register_stack_execute_unit.f
rtl/rsx_pkg.sv
rtl/rsx_ctrl.sv
rtl/rsx_datapath.sv
rtl/register_stack_execute_unit.sv
tb/sv/rsx_result_check.sv
tb/sv/testbench.sv
